// ===== src/rbt_pkg.sv =====
package rbt_pkg;

   localparam int BLOCK_LOG      = 3;
   localparam int BLOCK_SIZE     = 1 << BLOCK_LOG;
   localparam int AREA_LOG       = 2 * BLOCK_LOG;
   localparam int DEF_MAX_WIDTH  = 2048;

   localparam int SAMPLE_W       = 8;
   localparam int WIDTH_REG_W    = 12;
   localparam int HEIGHT_REG_W   = 16;
   localparam int BCOL_W         = 8;
   localparam int BROW_W         = 13;
   localparam int REQ_DATA_W     = 24;
   localparam int RSP_DATA_W     = 56;
   localparam int RSP_PAD_W      = RSP_DATA_W - (3 * SAMPLE_W + BCOL_W + BROW_W + AREA_LOG);

   localparam int CSR_IDX_W      = 1;
   localparam int CSR_DATA_W     = 16;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

   localparam logic [WIDTH_REG_W-1:0]  RESET_WIDTH  = 12'd8;
   localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT = 16'd8;

   localparam logic [SAMPLE_W-1:0] LEVEL_SHIFT = 8'd128;
   localparam logic [AREA_LOG-1:0] LAST_POS    = 6'd63;

   typedef struct packed {
      logic [SAMPLE_W-1:0] red;
      logic [SAMPLE_W-1:0] blue;
      logic [SAMPLE_W-1:0] luma;
   } pix_type;

   typedef struct packed {
      logic                pad;
      logic [BCOL_W-1:0]   bcol;
      logic [BROW_W-1:0]   brow;
      logic [AREA_LOG-1:0] pos;
      logic                last_blk;
      logic                last_img;
   } meta_type;

   // column counter width, at least one bit of block index
   function automatic int col_bits(input int max_width);
      int c;
      c = $clog2(max_width);
      col_bits = (c > BLOCK_LOG) ? c : BLOCK_LOG + 1;
   endfunction

endpackage

// ===== src/rbt_strip_mem.sv =====
module rbt_strip_mem
   import rbt_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [BLOCK_LOG+col_bits(MAX_WIDTH)-1:0] wr_addr,
   input  pix_type                                wr_data,
   input  logic                                   rd_en,
   input  logic [BLOCK_LOG+col_bits(MAX_WIDTH)-1:0] rd_addr,
   output pix_type                                rd_data
);

   localparam int COL_W  = col_bits(MAX_WIDTH);
   localparam int ADDR_W = BLOCK_LOG + COL_W;
   localparam int DEPTH  = 1 << ADDR_W;

   pix_type strip_ff [DEPTH];
   pix_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         strip_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= strip_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/rbt_ctrl.sv =====
module rbt_ctrl
   import rbt_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [REQ_DATA_W-1:0]                  req_tdata,
   input  logic                                   csr_wen,
   input  logic [CSR_IDX_W-1:0]                   csr_index,
   input  logic [CSR_DATA_W-1:0]                  csr_wdata,
   output logic                                   wr_en,
   output logic [BLOCK_LOG+col_bits(MAX_WIDTH)-1:0] wr_addr,
   output pix_type                                wr_data,
   output logic                                   rd_valid,
   input  logic                                   rd_ready,
   output logic                                   rd_en,
   output logic [BLOCK_LOG+col_bits(MAX_WIDTH)-1:0] rd_addr,
   output meta_type                               rd_meta
);

   localparam int COL_W = col_bits(MAX_WIDTH);
   localparam int WE_W  = COL_W + 1;
   localparam int BX_W  = COL_W - BLOCK_LOG;
   localparam int ROW_W = HEIGHT_REG_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic [WIDTH_REG_W-1:0]  width_ff,  width_in;
   logic [HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]        col_ff,    col_in;
   logic [ROW_W-1:0]        row_ff,    row_in;
   logic                    state_ff,  state_in;
   logic [BX_W-1:0]         blk_x_ff,  blk_x_in;
   logic [BROW_W-1:0]       blk_y_ff,  blk_y_in;
   logic                    img_end_ff, img_end_in;
   logic [AREA_LOG-1:0]     pos_ff,    pos_in;

   logic [31:0]             w_reg32;
   logic [31:0]             w_eff32;
   logic [WE_W-1:0]         w_eff;
   logic [COL_W-1:0]        w_last;
   logic [ROW_W-1:0]        h_eff;
   logic [ROW_W-1:0]        h_last;
   logic                    accept;
   logic                    right_done;
   logic                    bottom_done;
   logic                    image_end;
   logic                    issue;
   logic [COL_W-1:0]        px;
   logic [ROW_W-1:0]        py;
   logic [31:0]             bx32;

   always_comb begin
      w_reg32 = 32'(width_ff);
      if (w_reg32 == 32'd0) begin
         w_eff32 = 32'd1;
      end else if (w_reg32 > 32'(MAX_WIDTH)) begin
         w_eff32 = 32'(MAX_WIDTH);
      end else begin
         w_eff32 = w_reg32;
      end
   end

   assign w_eff  = w_eff32[WE_W-1:0];
   assign w_last = COL_W'(w_eff - WE_W'(1));
   assign h_eff  = (height_ff == '0) ? ROW_W'(1) : height_ff;
   assign h_last = h_eff - ROW_W'(1);

   assign req_tready  = (state_ff == ST_IDLE);
   assign accept      = req_tvalid && req_tready;
   assign right_done  = (col_ff[BLOCK_LOG-1:0] == '1) || (col_ff == w_last);
   assign bottom_done = (row_ff[BLOCK_LOG-1:0] == '1) || (row_ff == h_last);
   assign image_end   = (col_ff == w_last) && (row_ff == h_last);

   assign wr_en   = accept;
   assign wr_addr = {row_ff[BLOCK_LOG-1:0], col_ff};
   assign wr_data = pix_type'(req_tdata);

   assign rd_valid = (state_ff == ST_EMIT);
   assign issue    = rd_valid && rd_ready;
   assign rd_en    = issue;
   assign rd_addr  = {pos_ff[AREA_LOG-1:BLOCK_LOG], blk_x_ff, pos_ff[BLOCK_LOG-1:0]};

   assign px   = {blk_x_ff, pos_ff[BLOCK_LOG-1:0]};
   assign py   = {blk_y_ff, pos_ff[AREA_LOG-1:BLOCK_LOG]};
   assign bx32 = 32'(blk_x_ff);

   always_comb begin
      rd_meta.pad      = !(({1'b0, px} < w_eff) && (py < h_eff));
      rd_meta.bcol     = bx32[BCOL_W-1:0];
      rd_meta.brow     = blk_y_ff;
      rd_meta.pos      = pos_ff;
      rd_meta.last_blk = (pos_ff == LAST_POS);
      rd_meta.last_img = img_end_ff && (pos_ff == LAST_POS);
   end

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      state_in   = state_ff;
      blk_x_in   = blk_x_ff;
      blk_y_in   = blk_y_ff;
      img_end_in = img_end_ff;
      pos_in     = pos_ff;
      if (csr_wen) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH: begin
               width_in = csr_wdata[WIDTH_REG_W-1:0];
            end
            REG_IMAGE_HEIGHT: begin
               height_in = csr_wdata[HEIGHT_REG_W-1:0];
            end
            default: begin
            end
         endcase
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff != w_last) begin
            col_in = col_ff + COL_W'(1);
         end else begin
            col_in = '0;
            row_in = (row_ff == h_last) ? '0 : row_ff + ROW_W'(1);
         end
         if (right_done && bottom_done) begin
            state_in   = ST_EMIT;
            blk_x_in   = col_ff[COL_W-1:BLOCK_LOG];
            blk_y_in   = row_ff[ROW_W-1:BLOCK_LOG];
            img_end_in = image_end;
            pos_in     = '0;
         end
      end
      if (issue) begin
         pos_in = pos_ff + AREA_LOG'(1);
         if (pos_ff == LAST_POS) begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         col_ff    <= '0;
         row_ff    <= '0;
         state_ff  <= ST_IDLE;
         pos_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         state_ff  <= state_in;
         pos_ff    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_x_ff   <= blk_x_in;
      blk_y_ff   <= blk_y_in;
      img_end_ff <= img_end_in;
   end

   a_block_start: assert property (@(posedge clock) disable iff (reset)
      (accept && !csr_wen && right_done && bottom_done)
         |=> (state_ff == ST_EMIT) && (pos_ff == '0))
      else $error("completed block did not start emission");

   a_block_end: assert property (@(posedge clock) disable iff (reset)
      (issue && pos_ff == LAST_POS) |=> (state_ff == ST_IDLE))
      else $error("emission did not end after the last sample");

   a_image_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && !csr_wen && image_end) |=> (col_ff == '0) && (row_ff == '0))
      else $error("counters did not wrap at end of image");

   a_col_in_image: assert property (@(posedge clock) disable iff (reset)
      !csr_wen |=> ({1'b0, col_ff} < w_eff) || $past(csr_wen))
      else $error("column counter left the image");

endmodule

// ===== src/rbt_out_stage.sv =====
module rbt_out_stage
   import rbt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_valid,
   output logic                  rd_ready,
   input  meta_type              rd_meta,
   input  pix_type               rd_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser
);

   logic                  p1_valid_ff, p1_valid_in;
   meta_type              p1_meta_ff;
   logic                  out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic                  out_last_ff;
   logic                  out_user_ff;

   logic                  out_load;
   logic                  p1_load;
   logic [SAMPLE_W-1:0]   luma_s;
   logic [SAMPLE_W-1:0]   blue_s;
   logic [SAMPLE_W-1:0]   red_s;

   assign out_load = p1_valid_ff && (!out_valid_ff || rsp_tready);
   assign rd_ready = !p1_valid_ff || out_load;
   assign p1_load  = rd_valid && rd_ready;

   // level shift, padding positions read as zero
   assign luma_s = p1_meta_ff.pad ? '0 : rd_data.luma - LEVEL_SHIFT;
   assign blue_s = p1_meta_ff.pad ? '0 : rd_data.blue - LEVEL_SHIFT;
   assign red_s  = p1_meta_ff.pad ? '0 : rd_data.red  - LEVEL_SHIFT;

   always_comb begin
      p1_valid_in = p1_valid_ff;
      if (p1_load) begin
         p1_valid_in = 1'b1;
      end else if (out_load) begin
         p1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= p1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (p1_load) begin
         p1_meta_ff <= rd_meta;
      end
      if (out_load) begin
         out_data_ff <= {{RSP_PAD_W{1'b0}}, p1_meta_ff.pos, p1_meta_ff.brow,
                         p1_meta_ff.bcol, red_s, blue_s, luma_s};
         out_last_ff <= p1_meta_ff.last_blk;
         out_user_ff <= p1_meta_ff.last_img;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_user_ff;

   a_user_implies_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("end of image flagged off a block end");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (p1_valid_ff && !out_load) |=> p1_valid_ff && $stable(p1_meta_ff))
      else $error("pending read lost while output stalled");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("output item changed during stall");

endmodule

// ===== src/raster_to_block_tiler.sv =====
// Raster to 8x8 block tiler.
// req_* carries one YCbCr pixel per item in raster order into an eight-row
// strip memory; each component is level-shifted (minus 128) on read-out.
// The pixel that completes an 8x8 block (bottom-right, or at the right or
// bottom image edge) starts a read-out of that block's 64 items on rsp_*,
// row-major; positions outside the image carry zero samples. rsp_tlast
// marks the 64th item of a block, rsp_tuser the last item of the image.
// csr_* writes image_width (index 0) or image_height (index 1) and restarts
// the image at the next pixel; write only while the block is idle.
// A block-completing pixel holds req_tready low while the strip memory read
// port streams the block; other pixels are accepted as they arrive.
// The first item of a block passes the memory read register and the read
// stage into the output register; one item per cycle while rsp_tready is high.
// A stall on rsp_tready holds the output register and the read stage; the
// read-out pauses, nothing is dropped. New pixels are accepted while the
// last item of a previous block still waits in the output register.
// Reset (synchronous) restores 8x8 image size and the raster position;
// memory contents are not cleared.
module raster_to_block_tiler
   import rbt_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // luma_in, blue_diff_in, red_diff_in
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // luma_out, blue_diff_out, red_diff_out, block_col, block_row, pos_in_block
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser,  // last_of_image
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ADDR_W = BLOCK_LOG + col_bits(MAX_WIDTH);

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   pix_type           wr_data;
   logic              rd_valid;
   logic              rd_ready;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   meta_type          rd_meta;
   pix_type           rd_data;

   rbt_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_valid   (rd_valid),
      .rd_ready   (rd_ready),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_meta    (rd_meta)
   );

   rbt_strip_mem #(.MAX_WIDTH(MAX_WIDTH)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rbt_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .rd_valid   (rd_valid),
      .rd_ready   (rd_ready),
      .rd_meta    (rd_meta),
      .rd_data    (rd_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== bench/raster_to_block_tiler_tb.sv =====
module raster_to_block_tiler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rbt_pkg::*;

   localparam int MAX_W        = DEF_MAX_WIDTH;
   localparam int BLOCK_AREA   = BLOCK_SIZE * BLOCK_SIZE;
   localparam int SETTLE       = 8;
   localparam int RANDOM_ITEMS = 460;
   localparam int LIMIT        = 2_000_000;

   localparam int BCOL_LSB = 3 * SAMPLE_W;
   localparam int BROW_LSB = BCOL_LSB + BCOL_W;
   localparam int POS_LSB  = BROW_LSB + BROW_W;

   typedef struct packed {
      logic [SAMPLE_W-1:0] luma;
      logic [SAMPLE_W-1:0] blue;
      logic [SAMPLE_W-1:0] red;
      logic [BCOL_W-1:0]   bcol;
      logic [BROW_W-1:0]   brow;
      logic [AREA_LOG-1:0] pos;
      logic                last_blk;
      logic                last_img;
   } tile_sample_type;

   typedef enum logic {STEP_CSR, STEP_PIXEL} step_kind_type;

   typedef struct packed {
      step_kind_type         kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [REQ_DATA_W-1:0] word;
      logic                  typed;
      logic [REQ_DATA_W-1:0] shifted;  // first sample of the block: red, blue, luma
   } step_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tready = 1'b0;
   logic                  csr_wen    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;

   raster_to_block_tiler u_top (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // expected block contents
   logic [WIDTH_REG_W-1:0]  img_width  = RESET_WIDTH;
   logic [HEIGHT_REG_W-1:0] img_height = RESET_HEIGHT;
   int                      col_pos    = 0;
   int                      row_pos    = 0;
   logic [REQ_DATA_W-1:0]   strip [BLOCK_SIZE][MAX_W];
   tile_sample_type         samples_due [$];

   int mismatches = 0;
   int cycles     = 0;
   int gap_odds   = 4;
   int stall_odds = 4;
   int stall_left = 0;
   int odds_menu [4] = '{0, 3, 6, 12};

   step_type script [32] = '{
      '{STEP_CSR,   REG_IMAGE_WIDTH,  24'd1,       1'b0, 24'h0},
      '{STEP_CSR,   REG_IMAGE_HEIGHT, 24'd1,       1'b0, 24'h0},
      '{STEP_PIXEL, 1'b0,             24'h000000,  1'b1, 24'h808080},
      '{STEP_PIXEL, 1'b0,             24'hFFFFFF,  1'b1, 24'h7F7F7F},
      '{STEP_PIXEL, 1'b0,             24'h808080,  1'b1, 24'h000000},
      '{STEP_PIXEL, 1'b0,             24'h01817F,  1'b1, 24'h8101FF},
      '{STEP_PIXEL, 1'b0,             24'h3C5AA5,  1'b1, 24'hBCDA25},
      // zero width with junk above the register, zero height
      '{STEP_CSR,   REG_IMAGE_WIDTH,  24'h00F000,  1'b0, 24'h0},
      '{STEP_CSR,   REG_IMAGE_HEIGHT, 24'h000000,  1'b0, 24'h0},
      '{STEP_PIXEL, 1'b0,             24'h123456,  1'b0, 24'h0},
      // partial 3x2 block, restarted by a write mid-image
      '{STEP_CSR,   REG_IMAGE_WIDTH,  24'd3,       1'b0, 24'h0},
      '{STEP_CSR,   REG_IMAGE_HEIGHT, 24'd2,       1'b0, 24'h0},
      '{STEP_PIXEL, 1'b0,             24'hA0B0C0,  1'b0, 24'h0},
      '{STEP_PIXEL, 1'b0,             24'h0F1E2D,  1'b0, 24'h0},
      '{STEP_CSR,   REG_IMAGE_HEIGHT, 24'd2,       1'b0, 24'h0},
      '{STEP_PIXEL, 1'b0,             24'h102030,  1'b0, 24'h0},
      '{STEP_PIXEL, 1'b0,             24'h405060,  1'b0, 24'h0},
      '{STEP_PIXEL, 1'b0,             24'h708090,  1'b0, 24'h0},
      '{STEP_PIXEL, 1'b0,             24'hA0B0C0,  1'b0, 24'h0},
      '{STEP_PIXEL, 1'b0,             24'hD0E0F0,  1'b0, 24'h0},
      '{STEP_PIXEL, 1'b0,             24'hFF0001,  1'b0, 24'h0},
      // one full-width block then a one-column block
      '{STEP_CSR,   REG_IMAGE_WIDTH,  24'd9,       1'b0, 24'h0},
      '{STEP_CSR,   REG_IMAGE_HEIGHT, 24'd1,       1'b0, 24'h0},
      '{STEP_PIXEL, 1'b0,             24'h111111,  1'b0, 24'h0},
      '{STEP_PIXEL, 1'b0,             24'h222222,  1'b0, 24'h0},
      '{STEP_PIXEL, 1'b0,             24'h333333,  1'b0, 24'h0},
      '{STEP_PIXEL, 1'b0,             24'h444444,  1'b0, 24'h0},
      '{STEP_PIXEL, 1'b0,             24'h555555,  1'b0, 24'h0},
      '{STEP_PIXEL, 1'b0,             24'h666666,  1'b0, 24'h0},
      '{STEP_PIXEL, 1'b0,             24'h777777,  1'b0, 24'h0},
      '{STEP_PIXEL, 1'b0,             24'h888888,  1'b0, 24'h0},
      '{STEP_PIXEL, 1'b0,             24'h999999,  1'b0, 24'h0}
   };

   function automatic void tile_pixel(input logic [REQ_DATA_W-1:0] pix);
      int              w, h, x, y, px, py, r, c;
      tile_sample_type s;
      pix_type         v;
      w = (img_width == 0) ? 1 : ((img_width > MAX_W) ? MAX_W : int'(img_width));
      h = (img_height == 0) ? 1 : int'(img_height);
      x = col_pos;
      y = row_pos;
      strip[y % BLOCK_SIZE][x] = pix;
      if ((x % BLOCK_SIZE == BLOCK_SIZE - 1 || x == w - 1) &&
          (y % BLOCK_SIZE == BLOCK_SIZE - 1 || y == h - 1)) begin
         for (r = 0; r < BLOCK_SIZE; r++) begin
            for (c = 0; c < BLOCK_SIZE; c++) begin
               px = (x / BLOCK_SIZE) * BLOCK_SIZE + c;
               py = (y / BLOCK_SIZE) * BLOCK_SIZE + r;
               s = '0;
               // padding outside the image stays zero
               if (px < w && py < h) begin
                  v = strip[r][px];
                  s.luma = v.luma - LEVEL_SHIFT;
                  s.blue = v.blue - LEVEL_SHIFT;
                  s.red  = v.red - LEVEL_SHIFT;
               end
               s.bcol     = BCOL_W'(x / BLOCK_SIZE);
               s.brow     = BROW_W'(y / BLOCK_SIZE);
               s.pos      = AREA_LOG'(r * BLOCK_SIZE + c);
               s.last_blk = (s.pos == LAST_POS);
               s.last_img = s.last_blk && x == w - 1 && y == h - 1;
               samples_due.push_back(s);
            end
         end
      end
      if (x + 1 < w) begin
         col_pos = x + 1;
      end else begin
         col_pos = 0;
         row_pos = (y + 1 < h) ? y + 1 : 0;
      end
   endfunction

   function automatic logic [REQ_DATA_W-1:0] random_pixel();
      logic [REQ_DATA_W-1:0] pix;
      logic [SAMPLE_W-1:0]   corner [4];
      corner = '{8'h00, 8'hFF, 8'h7F, 8'h80};
      pix = REQ_DATA_W'($urandom);
      if ($urandom_range(7, 0) == 0) begin
         pix = {corner[$urandom_range(3, 0)], corner[$urandom_range(3, 0)],
                corner[$urandom_range(3, 0)]};
      end
      return pix;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   task automatic send_pixel(input logic [REQ_DATA_W-1:0] pix);
      if (gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(9, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
      tile_pixel(pix);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (samples_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (idx == REG_IMAGE_WIDTH) begin
         img_width = value[WIDTH_REG_W-1:0];
      end else begin
         img_height = value;
      end
      col_pos = 0;
      row_pos = 0;
      @(posedge clock);
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (stall_odds != 0 && $urandom_range(stall_odds - 1, 0) == 0) begin
            stall_left = $urandom_range(8, 0);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      tile_sample_type want;
      if (rsp_tvalid && rsp_tready) begin
         if (samples_due.size() == 0) begin
            $error("result item with nothing pending: tdata %h", rsp_tdata);
            mismatches++;
         end else begin
            want = samples_due.pop_front();
            check_field("luma_out", $signed(want.luma), $signed(rsp_tdata[0 +: SAMPLE_W]));
            check_field("blue_diff_out", $signed(want.blue),
                        $signed(rsp_tdata[SAMPLE_W +: SAMPLE_W]));
            check_field("red_diff_out", $signed(want.red),
                        $signed(rsp_tdata[2 * SAMPLE_W +: SAMPLE_W]));
            check_field("block_col", want.bcol, rsp_tdata[BCOL_LSB +: BCOL_W]);
            check_field("block_row", want.brow, rsp_tdata[BROW_LSB +: BROW_W]);
            check_field("pos_in_block", want.pos, rsp_tdata[POS_LSB +: AREA_LOG]);
            check_field("last_of_block", want.last_blk, rsp_tlast);
            check_field("last_of_image", want.last_img, rsp_tuser);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("raster_to_block_tiler test failed");
         $finish;
      end
   end

   initial begin
      int                    n, k, area, ew, eh, mode, fed, first;
      bit                    wide_done;
      logic [CSR_DATA_W-1:0] wval, hval;
      pix_type               t;
      fed = 0;
      wide_done = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == STEP_CSR) begin
            settle();
            write_reg(script[i].idx, script[i].word[CSR_DATA_W-1:0]);
         end else begin
            send_pixel(script[i].word);
            if (script[i].typed) begin
               t = script[i].shifted;
               first = samples_due.size() - BLOCK_AREA;
               samples_due[first].luma = t.luma;
               samples_due[first].blue = t.blue;
               samples_due[first].red  = t.red;
            end
         end
      end

      while (fed < RANDOM_ITEMS) begin
         if (fed >= RANDOM_ITEMS - 60) begin
            gap_odds   = 0;
            stall_odds = 0;
         end else begin
            gap_odds   = odds_menu[$urandom_range(3, 0)];
            stall_odds = odds_menu[$urandom_range(3, 0)];
         end

         if (!wide_done && fed >= 200) begin
            // width beyond the store saturates, one short row run
            settle();
            wval = CSR_DATA_W'($urandom);
            wval[WIDTH_REG_W-1:0] = WIDTH_REG_W'($urandom_range(4095, MAX_W + 1));
            write_reg(REG_IMAGE_WIDTH, wval);
            write_reg(REG_IMAGE_HEIGHT, 16'd1);
            n = $urandom_range(40, 16);
            for (k = 0; k < n; k++) send_pixel(random_pixel());
            fed += n;
            wide_done = 1;
            continue;
         end

         mode = $urandom_range(15, 0);
         ew = $urandom_range(24, 1);
         eh = $urandom_range(17, 1);
         wval = CSR_DATA_W'($urandom);
         wval[WIDTH_REG_W-1:0] = WIDTH_REG_W'(ew);
         hval = HEIGHT_REG_W'(eh);
         case (mode)
            0: begin
               wval[WIDTH_REG_W-1:0] = '0;
               ew = 1;
            end
            1: begin
               hval = '0;
               eh = 1;
            end
            2: begin
               ew = $urandom_range(MAX_W, MAX_W - 40);
               wval[WIDTH_REG_W-1:0] = WIDTH_REG_W'(ew);
               hval = 16'd1;
               eh = 1;
            end
            3: begin
               hval = '1;
               eh = 65535;
            end
            default: ;
         endcase

         settle();
         if ($urandom_range(7, 0) != 0) begin
            if ($urandom_range(1, 0) == 1) begin
               write_reg(REG_IMAGE_WIDTH, wval);
               write_reg(REG_IMAGE_HEIGHT, hval);
            end else begin
               write_reg(REG_IMAGE_HEIGHT, hval);
               write_reg(REG_IMAGE_WIDTH, wval);
            end
         end

         area = ew * eh;
         if (area > 150) begin
            n = $urandom_range(150, 20);
         end else begin
            n = area * $urandom_range(2, 1) + $urandom_range(area - 1, 0);
         end
         for (k = 0; k < n; k++) begin
            if (k == n / 2 && $urandom_range(3, 0) == 0) settle();
            send_pixel(random_pixel());
         end
         fed += n;
      end

      gap_odds   = 0;
      stall_odds = 0;
      settle();
      if (mismatches == 0) begin
         $display("raster_to_block_tiler test passed");
      end else begin
         $display("raster_to_block_tiler test failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/rbt_pkg.sv
src/rbt_strip_mem.sv
src/rbt_ctrl.sv
src/rbt_out_stage.sv
src/raster_to_block_tiler.sv
bench/raster_to_block_tiler_tb.sv
